>>> hw/rtl/rsc_encoder_with_termination_macros.svh
// ----------------------------------------------------------------------------
// rsc encoder assertion macros
// shared property forms for the encoder's concurrent checks
// ----------------------------------------------------------------------------
`ifndef RSC_ENCODER_WITH_TERMINATION_MACROS_SVH
`define RSC_ENCODER_WITH_TERMINATION_MACROS_SVH

// condition holds at every clock edge out of reset
`define RSC_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RSC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rsc_enc_pkg.sv
// ----------------------------------------------------------------------------
// rsc encoder package
// shared types and constants of the recursive systematic convolutional encoder
// ----------------------------------------------------------------------------
package rsc_enc_pkg;

    localparam int MAX_MEMORY_DEF = 8;
    localparam int V_CAP          = 8;
    localparam int MEM_LEN_W      = 4;
    localparam int TAP_W          = 9;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_IDX_W      = 2;

    localparam logic [MEM_LEN_W-1:0] MEM_LEN_RESET = MEM_LEN_W'(3);
    localparam logic [TAP_W-1:0]     FB_TAPS_RESET = TAP_W'(11);
    localparam logic [TAP_W-1:0]     OUT_TAPS_RESET = TAP_W'(13);

    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_TAPS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TAPS   = CFG_IDX_W'(2);

    typedef struct packed {
        logic data_bit;
        logic block_end;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [MEM_LEN_W-1:0] v;
        logic [TAP_W-1:0]     fb_taps;
        logic [TAP_W-1:0]     out_taps;
        logic                 clear;
    } cfg_t;

endpackage

>>> hw/rtl/rsc_enc_front.sv
// ----------------------------------------------------------------------------
// rsc encoder front end
// accepts input items into a two-entry queue ahead of the trellis engine
// ----------------------------------------------------------------------------
module rsc_enc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      data_valid,
    output logic                      data_ready,
    input  logic                      data_bit,
    input  logic                      block_end,
    output rsc_enc_pkg::queue_head_t  head,
    input  logic                      pop
);
    import rsc_enc_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    assign data_ready = (count_reg != 2'd2);
    assign push       = data_valid && data_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{data_bit: data_bit, block_end: block_end};
        end
    end

endmodule

>>> hw/rtl/rsc_enc_back.sv
// ----------------------------------------------------------------------------
// rsc encoder trellis engine
// runs one trellis step per cycle, data steps then tail steps, into a result register; a held result stalls it
// ----------------------------------------------------------------------------
`include "rsc_encoder_with_termination_macros.svh"

module rsc_enc_back #(
    parameter int SR_W = rsc_enc_pkg::V_CAP
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rsc_enc_pkg::cfg_t        cfg,
    input  rsc_enc_pkg::queue_head_t head,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     parity_bit,
    output logic                     systematic_bit,
    output logic                     is_tail,
    output logic                     last
);
    import rsc_enc_pkg::*;

    logic [SR_W-1:0]      sr_reg;
    logic [SR_W-1:0]      sr_next;
    logic [MEM_LEN_W-1:0] tail_cnt_reg;
    logic [MEM_LEN_W-1:0] tail_cnt_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic                 parity_reg;
    logic                 sys_reg;
    logic                 tail_reg;
    logic                 last_reg;

    logic [SR_W-1:0]      mask;
    logic [SR_W-1:0]      sr_m;
    logic [TAP_W-1:0]     sr_ext;
    logic                 emit_ok;
    logic                 do_tail;
    logic                 do_data;
    logic                 tail_in;
    logic                 in_bit;
    logic                 fb;
    logic                 par;
    logic [SR_W-1:0]      step_sr;

    assign emit_ok = !result_valid_reg || result_ready;
    assign do_tail = emit_ok && (tail_cnt_reg != '0);
    assign do_data = emit_ok && (tail_cnt_reg == '0) && head.valid;
    assign pop     = do_data;

    always_comb
    begin
        for (int i = 0; i < SR_W; i++)
        begin
            mask[i] = (i < int'(cfg.v));
        end
        sr_m    = sr_reg & mask;
        sr_ext  = TAP_W'(sr_m);
        tail_in = ^(sr_ext & cfg.fb_taps);
        in_bit  = do_tail ? tail_in : head.item.data_bit;
        fb      = ^((sr_ext | (TAP_W'(in_bit) << cfg.v)) & cfg.fb_taps);
        par     = ^((sr_ext | (TAP_W'(fb) << cfg.v)) & cfg.out_taps);
        step_sr = ((sr_m >> 1) | (SR_W'(fb) << (cfg.v - MEM_LEN_W'(1)))) & mask;
    end

    always_comb
    begin
        sr_next           = sr_reg;
        tail_cnt_next     = tail_cnt_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (do_tail)
        begin
            sr_next           = step_sr;
            tail_cnt_next     = tail_cnt_reg - MEM_LEN_W'(1);
            result_valid_next = 1'b1;
        end
        else if (do_data)
        begin
            sr_next           = step_sr;
            tail_cnt_next     = head.item.block_end ? cfg.v : '0;
            result_valid_next = 1'b1;
        end
        if (cfg.clear)
        begin
            sr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg           <= '0;
            tail_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sr_reg           <= sr_next;
            tail_cnt_reg     <= tail_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_tail || do_data)
        begin
            parity_reg <= par;
            sys_reg    <= in_bit;
            tail_reg   <= do_tail;
            last_reg   <= do_tail && (tail_cnt_reg == MEM_LEN_W'(1));
        end
    end

    assign result_valid   = result_valid_reg;
    assign parity_bit     = parity_reg;
    assign systematic_bit = sys_reg;
    assign is_tail        = tail_reg;
    assign last           = last_reg;

    `RSC_ASSERT_HOLDS(a_tail_cnt_bound, tail_cnt_reg <= cfg.v, "tail count above memory length")
    `RSC_ASSERT_IMPLIES(a_last_is_tail, result_valid_reg && last_reg, tail_reg, "last on data step")
    `RSC_ASSERT_IMPLIES(a_pop_no_tail, pop, tail_cnt_reg == '0, "item taken during termination")
    `RSC_ASSERT_NEXT(a_tail_start, do_data && head.item.block_end, tail_cnt_reg == $past(cfg.v), "tail run not started")

endmodule

>>> hw/rtl/rsc_encoder_with_termination.sv
// ----------------------------------------------------------------------------
// rsc encoder with termination
// recursive systematic convolutional encoder, one data bit per item, v tail
// steps after each block end item. Items enter a two-entry queue; while
// results are taken, the trellis engine pops one item per cycle and computes
// one result per cycle into a result register, so plain items flow at one per
// cycle. A block end item then holds the single trellis step unit for v tail
// steps, during which the queue absorbs up to two further items. Configuration
// writes clear the shift register and must be made while the encoder is idle.
// ----------------------------------------------------------------------------
module rsc_encoder_with_termination #(
    parameter int MAX_MEMORY = rsc_enc_pkg::MAX_MEMORY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rsc_enc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsc_enc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                  data_valid,
    output logic                                  data_ready,
    input  logic                                  data_bit,
    input  logic                                  block_end,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic                                  parity_bit,
    output logic                                  systematic_bit,
    output logic                                  is_tail,
    output logic                                  last
);
    import rsc_enc_pkg::*;

    localparam int V_LIMIT = (MAX_MEMORY < V_CAP) ? MAX_MEMORY : V_CAP;

    logic [MEM_LEN_W-1:0] mem_len_reg;
    logic [TAP_W-1:0]     fb_taps_reg;
    logic [TAP_W-1:0]     out_taps_reg;
    logic [MEM_LEN_W-1:0] v_eff;
    cfg_t                 cfg;
    queue_head_t          head;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_len_reg  <= MEM_LEN_RESET;
            fb_taps_reg  <= FB_TAPS_RESET;
            out_taps_reg <= OUT_TAPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MEMORY_LENGTH: mem_len_reg  <= cfg_data[MEM_LEN_W-1:0];
                REG_FEEDBACK_TAPS: fb_taps_reg  <= cfg_data[TAP_W-1:0];
                REG_OUTPUT_TAPS:   out_taps_reg <= cfg_data[TAP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (mem_len_reg == '0)
        begin
            v_eff = MEM_LEN_W'(1);
        end
        else if (mem_len_reg > MEM_LEN_W'(V_LIMIT))
        begin
            v_eff = MEM_LEN_W'(V_LIMIT);
        end
        else
        begin
            v_eff = mem_len_reg;
        end
    end

    assign cfg.v        = v_eff;
    assign cfg.fb_taps  = fb_taps_reg;
    assign cfg.out_taps = out_taps_reg;
    assign cfg.clear    = cfg_we && ((cfg_index == REG_MEMORY_LENGTH)
                                  || (cfg_index == REG_FEEDBACK_TAPS)
                                  || (cfg_index == REG_OUTPUT_TAPS));

    rsc_enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_bit   (data_bit),
        .block_end  (block_end),
        .head       (head),
        .pop        (pop)
    );

    rsc_enc_back #(
        .SR_W (V_LIMIT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .head           (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .parity_bit     (parity_bit),
        .systematic_bit (systematic_bit),
        .is_tail        (is_tail),
        .last           (last)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// rsc encoder with termination testbench
// drives data items through the encoder under several tap and memory
// settings, predicts every data and tail result from an internal trellis
// model, and checks each result in order while both sides idle at random
// in every phase but the last
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_enc_pkg::*;

    localparam int V_LIMIT = (MAX_MEMORY_DEF < V_CAP) ? MAX_MEMORY_DEF : V_CAP;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        logic parity_bit;
        logic systematic_bit;
        logic is_tail;
        logic last;
    } symbol_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  data_valid = 1'b0;
    logic                  data_ready;
    logic                  data_bit = 1'b0;
    logic                  block_end = 1'b0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic                  parity_bit;
    logic                  systematic_bit;
    logic                  is_tail;
    logic                  last;

    item_t   bit_stream [$];
    symbol_t owed_symbols [$];

    logic [MEM_LEN_W-1:0] mem_len_copy = MEM_LEN_RESET;
    logic [TAP_W-1:0]     fb_taps_copy = FB_TAPS_RESET;
    logic [TAP_W-1:0]     out_taps_copy = OUT_TAPS_RESET;
    logic [7:0]           trellis_state = '0;

    int  bad_count = 0;
    int  cycle_count = 0;
    logic calm = 1'b0;

    rsc_encoder_with_termination dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .data_bit       (data_bit),
        .block_end      (block_end),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .parity_bit     (parity_bit),
        .systematic_bit (systematic_bit),
        .is_tail        (is_tail),
        .last           (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int memory_depth();
        int v;
        v = int'(mem_len_copy);
        if (v < 1)
        begin
            v = 1;
        end
        if (v > V_LIMIT)
        begin
            v = V_LIMIT;
        end
        return v;
    endfunction

    // one trellis step, advances trellis_state and returns the parity
    function automatic logic trellis_step(input int v, input logic in_bit);
        logic [8:0] mask;
        logic [8:0] reg_now;
        logic [8:0] word;
        logic       fb;
        logic       par;
        mask = (9'd1 << v) - 9'd1;
        reg_now = {1'b0, trellis_state} & mask;
        word = reg_now;
        word[v] = in_bit;
        fb = ^(word & fb_taps_copy);
        word = reg_now;
        word[v] = fb;
        par = ^(word & out_taps_copy);
        word = reg_now >> 1;
        word[v-1] = fb;
        word = word & mask;
        trellis_state = word[7:0];
        return par;
    endfunction

    function automatic void encode_item(input logic d, input logic ends_block);
        int         v;
        logic [8:0] mask;
        logic       t;
        logic       par;
        v = memory_depth();
        mask = (9'd1 << v) - 9'd1;
        par = trellis_step(v, d);
        owed_symbols.push_back('{par, d, 1'b0, 1'b0});
        if (ends_block)
        begin
            for (int i = 0; i < v; i++)
            begin
                t = ^(({1'b0, trellis_state} & mask) & fb_taps_copy);
                par = trellis_step(v, t);
                owed_symbols.push_back('{par, t, 1'b1, logic'(i == v - 1)});
            end
        end
    endfunction

    // driver
    always @(posedge clk)
    begin : driver
        int   send_gap;
        item_t next;
        if (rst_n)
        begin
            if (data_valid && data_ready)
            begin
                encode_item(data_bit, block_end);
            end
            if (!data_valid || data_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    data_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(0, 17);
                    data_valid <= 1'b0;
                end
                else if (bit_stream.size() != 0)
                begin
                    next = bit_stream.pop_front();
                    data_valid <= 1'b1;
                    data_bit <= next.data_bit;
                    block_end <= next.block_end;
                end
                else
                begin
                    data_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        int      sink_gap;
        symbol_t got;
        symbol_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got = {parity_bit, systematic_bit, is_tail, last};
                if (owed_symbols.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                    begin
                        $display("unexpected result: parity %b sys %b tail %b last %b",
                                 got.parity_bit, got.systematic_bit, got.is_tail, got.last);
                    end
                end
                else
                begin
                    want = owed_symbols.pop_front();
                    if (got.parity_bit !== want.parity_bit
                        || got.systematic_bit !== want.systematic_bit
                        || got.is_tail !== want.is_tail
                        || got.last !== want.last)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $display("mismatch: expected par %b sys %b tail %b last %b, %s",
                                     want.parity_bit, want.systematic_bit, want.is_tail,
                                     want.last, $sformatf("got par %b sys %b tail %b last %b",
                                     got.parity_bit, got.systematic_bit, got.is_tail,
                                     got.last));
                        end
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                result_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 17);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (bit_stream.size() != 0 || data_valid || owed_symbols.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MEMORY_LENGTH:
            begin
                mem_len_copy = val[MEM_LEN_W-1:0];
                trellis_state = '0;
            end
            REG_FEEDBACK_TAPS:
            begin
                fb_taps_copy = val[TAP_W-1:0];
                trellis_state = '0;
            end
            REG_OUTPUT_TAPS:
            begin
                out_taps_copy = val[TAP_W-1:0];
                trellis_state = '0;
            end
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly whole blocks closed by a block end, some loose bits
    task automatic queue_traffic(input int count);
        int    made;
        int    len;
        item_t it;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                begin
                    it.data_bit = 1'($urandom_range(0, 1));
                    it.block_end = (k == len - 1);
                    bit_stream.push_back(it);
                end
                made += len;
            end
            else
            begin
                it.data_bit = 1'($urandom_range(0, 1));
                it.block_end = 1'($urandom_range(0, 1));
                bit_stream.push_back(it);
                made++;
            end
        end
    endtask

    initial
    begin : stimulus
        item_t                opening [0:13];
        logic [MEM_LEN_W-1:0] mem;
        logic [TAP_W-1:0]     fb;
        logic [TAP_W-1:0]     outp;
        opening = '{2'b00, 2'b10, 2'b10, 2'b01, 2'b11, 2'b10, 2'b00,
                    2'b11, 2'b01, 2'b10, 2'b10, 2'b10, 2'b11, 2'b00};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: plain bits, back-to-back block ends, zero data ends
        foreach (opening[i])
        begin
            bit_stream.push_back(opening[i]);
        end

        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clk);
            fb = TAP_W'($urandom_range(0, 511));
            outp = TAP_W'($urandom_range(0, 511));
            case (p)
                0:
                begin
                    mem = MEM_LEN_W'(1);
                    fb = 9'h003;
                    outp = 9'h1ff;
                end
                1:
                begin
                    mem = MEM_LEN_W'(8);
                    fb = 9'h1ff;
                    outp = 9'h000;
                end
                2: mem = MEM_LEN_W'(0);
                4:
                begin
                    mem = MEM_LEN_W'(15);
                    fb = fb | 9'h100;
                end
                5:
                begin
                    mem = MEM_LEN_W'(9);
                    fb = 9'h000;
                    outp = 9'h1ff;
                end
                6:
                begin
                    mem = MEM_LEN_W'($urandom_range(1, 8));
                    fb = fb | (9'd1 << mem);
                end
                default: mem = MEM_LEN_W'($urandom_range(0, 15));
            endcase
            // spare index must leave the trellis state alone
            if (p == 3)
            begin
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
            end
            else
            begin
                write_reg(REG_MEMORY_LENGTH, CFG_DATA_W'(mem));
                write_reg(REG_FEEDBACK_TAPS, fb);
                write_reg(REG_OUTPUT_TAPS, outp);
            end
            if (p == 7)
            begin
                calm = 1'b1;
            end
            queue_traffic(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_symbols.size() != 0)
        begin
            bad_count++;
        end
        if (bad_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
